FILE: design/dvob_pkg.sv
// Shared types, register codes and constants for the disc versus oriented box scan.
package dvob_pkg;

  // Stream payload widths
  localparam int IN_TDATA_W  = 288;
  localparam int OUT_TDATA_W = 32;

  // Default depth of the front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [0:0] REG_STEP_HEIGHT  = 1'b0;
  localparam logic [0:0] REG_ACTOR_HEIGHT = 1'b1;

  // Reset values of the configuration registers (Q16.16)
  localparam logic [30:0] STEP_HEIGHT_RST  = 31'd32768;
  localparam logic [30:0] ACTOR_HEIGHT_RST = 31'd131072;

  // floor(2^34 / 5): reciprocal used to divide the probe numerator by five
  localparam logic [31:0] RECIP_5   = 32'd3435973836;
  localparam int          DIV_SHIFT = 34;

  // Half of one Q16.16 step in the Q16.30 rotation product
  localparam logic signed [50:0] ROUND_HALF = 51'sd8192;

  // Item kinds
  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_BOX   = 1'b1
  } op_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRY_MUL,
    ST_QRY_DIV,
    ST_QRY_SQ,
    ST_BOX_MUL,
    ST_BOX_ROT,
    ST_BOX_CLAMP,
    ST_BOX_SQ,
    ST_FINISH
  } st_t;

  // One classified item as it sits in the queue
  typedef struct packed {
    op_t                op;
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic [30:0]        radius;
    logic [32:0]        probe_num;   // 4 * radius + 2, queries only
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic [30:0]        half_x;
    logic [30:0]        half_z;
    logic signed [31:0] base;
    logic signed [31:0] top;
  } item_t;

  // Configuration register file contents
  typedef struct packed {
    logic [30:0] step_height;
    logic [30:0] actor_height;
  } cfg_t;

endpackage

FILE: design/dvob_front.sv
// Front end: unpacks accepted input transactions and classifies them for the queue.
module dvob_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dvob_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  input  logic                             q_full,
  output logic                             q_push,
  output dvob_pkg::item_t                  q_item
);
  import dvob_pkg::*;

  logic [30:0] radius;

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  assign radius = in_tdata[126:96];

  // Unpack the payload and tag the item kind
  always_comb begin
    q_item           = '0;
    q_item.op        = (in_tuser == 1'b0) ? OP_QUERY : OP_BOX;
    q_item.last      = in_tlast;
    q_item.x         = in_tdata[31:0];
    q_item.z         = in_tdata[63:32];
    q_item.y         = in_tdata[95:64];
    q_item.radius    = radius;
    q_item.cos_v     = in_tdata[142:127];
    q_item.sin_v     = in_tdata[158:143];
    q_item.half_x    = in_tdata[189:159];
    q_item.half_z    = in_tdata[220:190];
    q_item.base      = in_tdata[252:221];
    q_item.top       = in_tdata[284:253];
    // Queries carry the rounding numerator of the 0.8 probe radius
    if (q_item.op == OP_QUERY) begin
      q_item.probe_num = {radius, 2'b00} + 33'd2;
    end
  end

endmodule

FILE: design/dvob_fifo.sv
// Short queue of classified items between the front and back ends.
module dvob_fifo #(
  parameter int DEPTH = dvob_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dvob_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output dvob_pkg::item_t head_item
);
  import dvob_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store incoming items
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/dvob_back.sv
// Back end: sequences query setup and box tests, accumulates and holds the result.
module dvob_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dvob_pkg::cfg_t                   cfg,
  input  logic                             head_valid,
  input  dvob_pkg::item_t                  head_item,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dvob_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dvob_pkg::*;

  st_t   state_r;
  st_t   state_nxt;
  item_t cur_r;

  // Query state
  logic signed [31:0] query_x_r;
  logic signed [31:0] query_z_r;
  logic signed [31:0] query_feet_r;
  logic [61:0]        radius_sq_r;
  logic [61:0]        probe_sq_r;

  // Accumulators
  logic        hit_r;
  logic        hit_nxt;
  logic [30:0] best_r;
  logic [30:0] best_nxt;

  // Query datapath
  logic [61:0] rsq_prod_r;
  logic [64:0] div_prod;
  logic [30:0] div_q_r;
  logic [33:0] five_q;
  logic [33:0] div_rem;
  logic [30:0] probe_r;

  // Box datapath
  logic signed [32:0] dx;
  logic signed [32:0] dz;
  logic signed [48:0] p_xc_r;
  logic signed [48:0] p_zs_r;
  logic signed [48:0] p_xs_r;
  logic signed [48:0] p_zc_r;
  logic signed [32:0] body_lo;
  logic signed [32:0] body_hi;
  logic signed [32:0] top_ext;
  logic signed [32:0] base_ext;
  logic               blk_span_r;
  logic               flr_span_r;
  logic signed [50:0] rx_sum;
  logic signed [50:0] rz_sum;
  logic signed [36:0] lx_r;
  logic signed [36:0] lz_r;
  logic signed [36:0] hx_ext;
  logic signed [36:0] hz_ext;
  logic signed [37:0] ex;
  logic signed [37:0] ez;
  logic [30:0]        ex_r;
  logic [30:0]        ez_r;
  logic               far_r;
  logic [61:0]        sqx_r;
  logic [61:0]        sqz_r;
  logic [62:0]        dist_sq;
  logic               blk_ov;
  logic               flr_ov;
  logic               is_box;
  logic               top_above;
  logic               acc_hit;
  logic [30:0]        acc_best;

  // Output register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic                   slot_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign slot_free  = !out_valid_r || out_tready;

  // Divide 4r+2 by five: reciprocal estimate, then one correction step
  assign div_prod = {32'b0, cur_r.probe_num} * {33'b0, RECIP_5};
  assign five_q   = {1'b0, div_q_r, 2'b00} + {3'b0, div_q_r};
  assign div_rem  = {1'b0, cur_r.probe_num} - five_q;

  // Offsets from box center and body span
  assign dx       = {query_x_r[31], query_x_r} - {cur_r.x[31], cur_r.x};
  assign dz       = {query_z_r[31], query_z_r} - {cur_r.z[31], cur_r.z};
  assign body_lo  = {query_feet_r[31], query_feet_r} + {2'b00, cfg.step_height};
  assign body_hi  = {query_feet_r[31], query_feet_r} + {2'b00, cfg.actor_height};
  assign top_ext  = {cur_r.top[31], cur_r.top};
  assign base_ext = {cur_r.base[31], cur_r.base};

  // Rotate into box frame, round Q16.30 half up to Q16.16
  assign rx_sum = 51'(p_xc_r) - 51'(p_zs_r) + ROUND_HALF;
  assign rz_sum = 51'(p_xs_r) + 51'(p_zc_r) + ROUND_HALF;

  // Residual outside the box extent on each local axis
  assign hx_ext = {6'b0, cur_r.half_x};
  assign hz_ext = {6'b0, cur_r.half_z};

  always_comb begin
    ex = '0;
    if (lx_r > hx_ext) begin
      ex = 38'(lx_r) - 38'(hx_ext);
    end else if (lx_r < -hx_ext) begin
      ex = -38'(hx_ext) - 38'(lx_r);
    end
    ez = '0;
    if (lz_r > hz_ext) begin
      ez = 38'(lz_r) - 38'(hz_ext);
    end else if (lz_r < -hz_ext) begin
      ez = -38'(hz_ext) - 38'(lz_r);
    end
  end

  // Overlap decisions and accumulator update for the finishing item
  assign dist_sq   = {1'b0, sqx_r} + {1'b0, sqz_r};
  assign blk_ov    = !far_r && (dist_sq < {1'b0, radius_sq_r});
  assign flr_ov    = !far_r && (dist_sq < {1'b0, probe_sq_r});
  assign is_box    = (cur_r.op == OP_BOX);
  assign top_above = top_ext > $signed({2'b00, best_r});
  assign acc_hit   = hit_r || (is_box && blk_span_r && blk_ov);
  assign acc_best  = (is_box && flr_span_r && top_above && flr_ov) ? cur_r.top[30:0] : best_r;

  // Sequencer: next state, queue pop, accumulators and output slot
  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    hit_nxt       = hit_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          state_nxt = (head_item.op == OP_QUERY) ? ST_QRY_MUL : ST_BOX_MUL;
        end
      end
      ST_QRY_MUL:   state_nxt = ST_QRY_DIV;
      ST_QRY_DIV:   state_nxt = ST_QRY_SQ;
      ST_QRY_SQ: begin
        hit_nxt   = 1'b0;
        best_nxt  = '0;
        state_nxt = ST_FINISH;
      end
      ST_BOX_MUL:   state_nxt = ST_BOX_ROT;
      ST_BOX_ROT:   state_nxt = ST_BOX_CLAMP;
      ST_BOX_CLAMP: state_nxt = ST_BOX_SQ;
      ST_BOX_SQ:    state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!cur_r.last) begin
          hit_nxt   = acc_hit;
          best_nxt  = acc_best;
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          // Emit and clear; hold here while the output slot is occupied
          out_valid_nxt = 1'b1;
          out_data_nxt  = {acc_best, acc_hit};
          hit_nxt       = 1'b0;
          best_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hit_r        <= 1'b0;
      best_r       <= '0;
      out_valid_r  <= 1'b0;
      query_x_r    <= '0;
      query_z_r    <= '0;
      query_feet_r <= '0;
      radius_sq_r  <= '0;
      probe_sq_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      // Commit a new query
      if (state_r == ST_QRY_SQ) begin
        query_x_r    <= cur_r.x;
        query_z_r    <= cur_r.z;
        query_feet_r <= cur_r.y;
        radius_sq_r  <= rsq_prod_r;
        probe_sq_r   <= probe_r * probe_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      cur_r <= head_item;
    end
    case (state_r)
      ST_QRY_MUL: begin
        rsq_prod_r <= cur_r.radius * cur_r.radius;
        div_q_r    <= div_prod[64:DIV_SHIFT];
      end
      ST_QRY_DIV: begin
        probe_r <= (div_rem >= 34'd5) ? div_q_r + 31'd1 : div_q_r;
      end
      ST_BOX_MUL: begin
        p_xc_r     <= dx * cur_r.cos_v;
        p_zs_r     <= dz * cur_r.sin_v;
        p_xs_r     <= dx * cur_r.sin_v;
        p_zc_r     <= dz * cur_r.cos_v;
        blk_span_r <= !((body_lo >= top_ext) || (body_hi <= base_ext));
        flr_span_r <= (top_ext <= body_lo);
      end
      ST_BOX_ROT: begin
        lx_r <= rx_sum[50:14];
        lz_r <= rz_sum[50:14];
      end
      ST_BOX_CLAMP: begin
        ex_r  <= ex[30:0];
        ez_r  <= ez[30:0];
        far_r <= (ex[37:31] != '0) || (ez[37:31] != '0);
      end
      ST_BOX_SQ: begin
        sqx_r <= ex_r * ex_r;
        sqz_r <= ez_r * ez_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/disc_vs_oriented_box_scan.sv
// Top level of the disc versus oriented box scan: configuration registers and block wiring.
//
// A query transaction (tuser 0) loads the disc center, feet height and radius; box
// transactions (tuser 1) that follow are each tested for blocking against the body
// span and for floor support under a 0.8-radius probe. The transaction with tlast high
// produces one result: bit 0 the hit flag, bits 31:1 the highest reachable box top.
// Input transactions land in a short queue, so the input keeps flowing while the back
// end works; the back end handles one item at a time in a fixed sequence of register
// stages (for a box: rotation multiplies, rounding, clamp, squares, compare), and a final
// result may wait for the output register to drain. Configuration writes are always
// accepted and must be made while no item is in flight.
module disc_vs_oriented_box_scan #(
  parameter int QUEUE_DEPTH = dvob_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low bit up: coord_x[31:0], coord_z[63:32], coord_y[95:64],
  // disc_radius[126:96], cos_yaw[142:127], sin_yaw[158:143], half_x[189:159],
  // half_z[220:190], box_base[252:221], box_top[284:253], zero pad[287:285]
  input  logic [dvob_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,   // mode
  input  logic                             in_tlast,   // last_box
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low bit up: hit[0], floor_height[31:1]
  output logic [dvob_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [30:0]                      cfg_data
);
  import dvob_pkg::*;

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_push;
  item_t q_item;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_height  <= STEP_HEIGHT_RST;
      cfg_r.actor_height <= ACTOR_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_HEIGHT:  cfg_r.step_height  <= cfg_data;
        REG_ACTOR_HEIGHT: cfg_r.actor_height <= cfg_data;
        default: ;
      endcase
    end
  end

  dvob_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  dvob_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dvob_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
